>>> sv/bbf_pkg.sv
// ----------------------------------------------------------------------------
// bbf_pkg
// Shared types, constants and helpers for the block byte FIFO.
// ----------------------------------------------------------------------------
package bbf_pkg;

  localparam int unsigned DEPTH     = 256;
  localparam int unsigned MAX_BURST = 64;
  localparam int unsigned PTR_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned BURST_W   = $clog2(MAX_BURST + 1);
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned LOST_W    = 32;
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QPTR_W    = $clog2(QDEPTH);
  localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);

  // transaction kinds
  localparam logic [2:0] KIND_PUT     = 3'd0;
  localparam logic [2:0] KIND_GET     = 3'd1;
  localparam logic [2:0] KIND_PEEK    = 3'd2;
  localparam logic [2:0] KIND_DISCARD = 3'd3;
  localparam logic [2:0] KIND_FLUSH   = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_NOROOM  = 2'd2;
  localparam logic [1:0] ST_DROPPED = 2'd3;

  typedef struct packed {
    logic [2:0]       kind;
    logic [7:0]       data_byte;
    logic [LEN_W-1:0] op_length;
    logic             first_of_block;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [7:0]        read_byte;
    logic              last_of_run;
    logic [CNT_W-1:0]  moved_count;
    logic [CNT_W-1:0]  fill_level;
    logic [LOST_W-1:0] lost_blocks;
  } out_t;

  // work handed from front to back
  typedef struct packed {
    logic               is_burst;
    logic               wr_en;
    logic [PTR_W-1:0]   addr;
    logic [7:0]         wr_data;
    logic [BURST_W-1:0] len;
    logic [1:0]         status;
    logic [CNT_W-1:0]   moved;
    logic [CNT_W-1:0]   fill;
    logic [LOST_W-1:0]  lost;
  } job_t;

  // front status seen by back and top
  typedef struct packed {
    logic [CNT_W-1:0] cap;
    logic [CNT_W-1:0] used;
  } fst_t;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p,
                                                input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] n;
    n = {1'b0, p} + CNT_W'(1);
    return (n >= cap) ? '0 : n[PTR_W-1:0];
  endfunction

endpackage

>>> sv/bbf_front.sv
// ----------------------------------------------------------------------------
// bbf_front
// Accepts transactions, keeps pointers and counters, emits one job each.
// ----------------------------------------------------------------------------
module bbf_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [bbf_pkg::CNT_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  bbf_pkg::in_t              in_i,
  output logic                      push_o,
  output bbf_pkg::job_t             job_o,
  input  logic                      q_ready_i,
  output bbf_pkg::fst_t             fst_o
);
  import bbf_pkg::*;

  logic [CNT_W-1:0]  cap_q, cap_d;
  logic [PTR_W-1:0]  rp_q, rp_d, wp_q, wp_d;
  logic [CNT_W-1:0]  used_q, used_d;
  logic [LOST_W-1:0] lost_q, lost_d;
  logic [LEN_W-1:0]  left_q, left_d;
  logic              rej_q, rej_d;

  logic [CNT_W-1:0]  free;
  logic [CNT_W-1:0]  n_adv;
  logic [CNT_W:0]    rp_sum;
  logic [PTR_W-1:0]  rp_adv;
  logic              store_ok;
  logic [LEN_W-1:0]  len;

  assign in_ready_o = q_ready_i;
  assign push_o     = in_valid_i && q_ready_i;
  assign fst_o.cap  = cap_q;
  assign fst_o.used = used_q;

  assign len      = in_i.op_length;
  assign free     = cap_q - used_q;
  assign store_ok = used_q < cap_q;

  // read pointer advance by n_adv, n_adv <= used so one subtract wraps it
  always_comb begin
    priority if (in_i.kind == KIND_DISCARD) begin
      n_adv = (len > LEN_W'(used_q)) ? used_q : len[CNT_W-1:0];
    end else begin
      n_adv = len[CNT_W-1:0];
    end
    rp_sum = {2'b00, rp_q} + {1'b0, n_adv};
    rp_adv = (rp_sum >= {1'b0, cap_q}) ? PTR_W'(rp_sum - {1'b0, cap_q})
                                        : rp_sum[PTR_W-1:0];
  end

  always_comb begin
    cap_d  = cap_q;
    rp_d   = rp_q;
    wp_d   = wp_q;
    used_d = used_q;
    lost_d = lost_q;
    left_d = left_q;
    rej_d  = rej_q;

    job_o          = '0;
    job_o.addr     = wp_q;
    job_o.wr_data  = in_i.data_byte;
    job_o.status   = ST_OK;

    if (cfg_we_i) begin
      if (cfg_wdata_i != '0) begin
        cap_d  = (cfg_wdata_i > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cfg_wdata_i;
        rp_d   = '0;
        wp_d   = '0;
        used_d = '0;
        lost_d = '0;
        left_d = '0;
        rej_d  = 1'b0;
      end
    end else if (push_o) begin
      unique case (in_i.kind)
        KIND_PUT: begin
          if (in_i.first_of_block) begin
            left_d = '0;
            rej_d  = 1'b0;
            if (len == '0) begin
              job_o.status = ST_INVALID;
            end else if (len > LEN_W'(free)) begin
              lost_d       = lost_q + LOST_W'(1);
              rej_d        = 1'b1;
              left_d       = len - LEN_W'(1);
              job_o.status = ST_NOROOM;
            end else begin
              left_d = len - LEN_W'(1);
              if (store_ok) begin
                job_o.wr_en = 1'b1;
                wp_d        = ptr_next(wp_q, cap_q);
                used_d      = used_q + CNT_W'(1);
              end else begin
                job_o.status = ST_NOROOM;
              end
            end
          end else if (left_q == '0) begin
            job_o.status = ST_INVALID;
          end else begin
            left_d = left_q - LEN_W'(1);
            if (rej_q) begin
              job_o.status = ST_DROPPED;
            end else if (store_ok) begin
              job_o.wr_en = 1'b1;
              wp_d        = ptr_next(wp_q, cap_q);
              used_d      = used_q + CNT_W'(1);
            end else begin
              job_o.status = ST_NOROOM;
            end
          end
        end
        KIND_GET, KIND_PEEK: begin
          if (len == '0) begin
            job_o.status = ST_INVALID;
          end else if (len > LEN_W'(used_q) || len > LEN_W'(MAX_BURST)) begin
            job_o.status = ST_NOROOM;
          end else begin
            job_o.is_burst = 1'b1;
            job_o.addr     = rp_q;
            job_o.len      = len[BURST_W-1:0];
            if (in_i.kind == KIND_GET) begin
              used_d = used_q - len[CNT_W-1:0];
              rp_d   = rp_adv;
            end
          end
        end
        KIND_DISCARD: begin
          job_o.moved = n_adv;
          used_d      = used_q - n_adv;
          rp_d        = rp_adv;
        end
        KIND_FLUSH: begin
          rp_d   = '0;
          wp_d   = '0;
          used_d = '0;
        end
        default: begin
          job_o.status = ST_INVALID;
        end
      endcase
    end

    job_o.fill = used_d;
    job_o.lost = lost_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CNT_W'(DEPTH);
      rp_q   <= '0;
      wp_q   <= '0;
      used_q <= '0;
      lost_q <= '0;
      left_q <= '0;
      rej_q  <= 1'b0;
    end else begin
      cap_q  <= cap_d;
      rp_q   <= rp_d;
      wp_q   <= wp_d;
      used_q <= used_d;
      lost_q <= lost_d;
      left_q <= left_d;
      rej_q  <= rej_d;
    end
  end

endmodule

>>> sv/bbf_queue.sv
// ----------------------------------------------------------------------------
// bbf_queue
// Short job queue between front and back.
// ----------------------------------------------------------------------------
module bbf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bbf_pkg::job_t push_job_i,
  output logic          ready_o,
  output logic          valid_o,
  output bbf_pkg::job_t head_o,
  input  logic          pop_i
);
  import bbf_pkg::*;

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  assign ready_o = cnt_q != QCNT_W'(QDEPTH);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + QPTR_W'(1);
      if (pop_i)  rd_q <= rd_q + QPTR_W'(1);
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> sv/bbf_back.sv
// ----------------------------------------------------------------------------
// bbf_back
// Byte store and result path: writes put bytes, streams get/peek bursts.
// ----------------------------------------------------------------------------
module bbf_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [bbf_pkg::CNT_W-1:0] cap_i,
  input  logic                      job_valid_i,
  input  bbf_pkg::job_t             job_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output bbf_pkg::out_t             out_o
);
  import bbf_pkg::*;

  logic [7:0]         store_q [DEPTH];
  logic [7:0]         rdata_q;

  logic               busy_q;
  logic [PTR_W-1:0]   addr_q;
  logic [BURST_W-1:0] left_q;

  logic               pend_valid_q;
  out_t               pend_q;
  logic               pend_rd_q;
  out_t               pend_out;

  logic               out_valid_q;
  out_t               out_q;

  logic               adv_out, pend_free, step, burst_last;
  logic [PTR_W-1:0]   cur_addr;
  logic [BURST_W-1:0] cur_left;

  assign adv_out    = !out_valid_q || out_ready_i;
  assign pend_free  = !pend_valid_q || adv_out;
  assign step       = job_valid_i && pend_free;
  assign cur_addr   = busy_q ? addr_q : job_i.addr;
  assign cur_left   = busy_q ? left_q : job_i.len;
  assign burst_last = cur_left == BURST_W'(1);
  assign pop_o      = step && (!job_i.is_burst || burst_last);

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // pending result with the store byte merged in
  always_comb begin
    pend_out           = pend_q;
    pend_out.read_byte = pend_rd_q ? rdata_q : 8'h00;
  end

  // single port: a cycle either writes a put byte or reads a burst byte
  always_ff @(posedge clk_i) begin
    if (step && job_i.wr_en) begin
      store_q[job_i.addr] <= job_i.wr_data;
    end
    if (step && job_i.is_burst) begin
      rdata_q <= store_q[cur_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_free && step) begin
      pend_q.status      <= job_i.status;
      pend_q.read_byte   <= '0;
      pend_q.last_of_run <= !job_i.is_burst || burst_last;
      pend_q.moved_count <= job_i.moved;
      pend_q.fill_level  <= job_i.fill;
      pend_q.lost_blocks <= job_i.lost;
      pend_rd_q          <= job_i.is_burst;
    end
    if (adv_out && pend_valid_q) begin
      out_q <= pend_out;
    end
    if (step && job_i.is_burst) begin
      addr_q <= ptr_next(cur_addr, cap_i);
      left_q <= cur_left - BURST_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (step && job_i.is_burst) begin
        busy_q <= !burst_last;
      end
      if (pend_free) begin
        pend_valid_q <= step;
      end
      if (adv_out) begin
        out_valid_q <= pend_valid_q;
      end
    end
  end

endmodule

>>> sv/block_byte_fifo_top.sv
// ----------------------------------------------------------------------------
// block_byte_fifo_top
// Circular byte FIFO with all-or-nothing block puts and burst get/peek.
// ----------------------------------------------------------------------------
// Results pass the job queue, the pending stage and the output register.
// Throughput: one transaction per cycle while the job queue has room; bursts
//   of get/peek hold the single-port 256-byte store to their last byte.
// Reset: asynchronous active-low; capacity returns to 256, queue empty, lost
//   count zero. The byte store itself is not cleared; no clearing pass.
// ----------------------------------------------------------------------------
module block_byte_fifo_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration: capacity register
  input  logic                      cfg_we_i,
  input  logic [bbf_pkg::CNT_W-1:0] cfg_wdata_i,
  // input transactions
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  bbf_pkg::in_t              in_i,
  // result transactions
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output bbf_pkg::out_t             out_o
);
  import bbf_pkg::*;

  // Front: owns pointers, fill level, lost count and put-block tracking.
  // Every accepted transaction becomes exactly one job, fully classified.
  logic push;
  job_t push_job;
  fst_t fst;
  logic q_ready;

  // Queue: lets the front keep accepting while a burst drains in the back.
  logic q_valid;
  job_t head;
  logic pop;

  bbf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .push_o      (push),
    .job_o       (push_job),
    .q_ready_i   (q_ready),
    .fst_o       (fst)
  );

  bbf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .ready_o    (q_ready),
    .valid_o    (q_valid),
    .head_o     (head),
    .pop_i      (pop)
  );

  // Back: performs store writes in job order so bursts see earlier puts,
  // and holds results in a pending stage plus output register.
  bbf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cap_i       (fst.cap),
    .job_valid_i (q_valid),
    .job_i       (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  // capacity stays within the legal range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fst.cap != '0 && fst.cap <= CNT_W'(DEPTH))
    else $error("capacity out of range");

  // fill level never exceeds capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fst.used <= fst.cap)
    else $error("fill level above capacity");

  // only a successful burst produces non-final results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.last_of_run |-> out_o.status == ST_OK)
    else $error("non-final result with error status");

  // a queue pop only happens for a job that is present
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid)
    else $error("pop from empty job queue");

endmodule
